[rtl/core/terrain_slope_aspect_3x3_defines.svh]
// Assertion macros used by the top-level RTL file.
`ifndef TERRAIN_SLOPE_ASPECT_3X3_DEFINES_SVH
`define TERRAIN_SLOPE_ASPECT_3X3_DEFINES_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define TSA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define TSA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TSA_ASSERT(lbl, prop, msg)
`define TSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/tsa_pkg.sv]
package tsa_pkg;

   localparam int ELEVATION_BITS  = 20;
   localparam int SUM_BITS        = 23;
   localparam int PROD_BITS       = 48;
   localparam int LANE_BITS       = 64;
   localparam int Z_BITS          = 35;
   localparam int CORDIC_STEPS    = 30;
   localparam int STEP_BITS       = 5;
   localparam int MAX_COLUMNS     = 1024;
   localparam int COL_BITS        = 10;
   localparam int ROW_BITS        = 12;
   localparam int MAX_ROWS        = 4096;
   localparam int ROW_CNT_BITS    = 13;
   localparam int COL_CNT_BITS    = 11;
   localparam int SCALE_BITS      = 24;
   localparam int SLOPE_BITS      = 17;
   localparam int ASPECT_BITS     = 19;
   localparam int ASPECT_PRESCALE = 38;
   localparam int ANGLE_SHIFT     = 14;

   localparam logic signed [Z_BITS-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [Z_BITS-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [Z_BITS-1:0] ROUND_HALF  = 35'sd8192;
   localparam logic signed [Z_BITS-1:0] ASPECT_MAX  = 35'sd411774;
   localparam logic signed [LANE_BITS-1:0] GAIN_Q24 = 64'sd27628053;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_ROW_COUNT      = 2'd0,
      REG_COLUMN_COUNT   = 2'd1,
      REG_GRADIENT_SCALE = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   // one CORDIC lane travelling along the chain
   typedef struct packed {
      logic signed [LANE_BITS-1:0] x;
      logic signed [LANE_BITS-1:0] y;
      logic signed [Z_BITS-1:0]    z;
   } lane_type;

   // window outcome for the transaction being accepted
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sx;
      logic signed [SUM_BITS-1:0] sy;
      logic [ROW_BITS-1:0]        row;
      logic [COL_BITS-1:0]        col;
      logic                       interior;
      logic                       border;
   } win_type;

   // truncated Q30 table of atan(2^-i)
   function automatic logic signed [Z_BITS-1:0] atan_q30(input logic [STEP_BITS-1:0] i);
      logic signed [Z_BITS-1:0] r;
      unique case (i)
         5'd0:  r = 35'sh03243F6A8;
         5'd1:  r = 35'sh01DAC6705;
         5'd2:  r = 35'sh00FADBAFC;
         5'd3:  r = 35'sh007F56EA6;
         5'd4:  r = 35'sh003FEAB76;
         5'd5:  r = 35'sh001FFD55B;
         5'd6:  r = 35'sh000FFFAAA;
         5'd7:  r = 35'sh0007FFF55;
         5'd8:  r = 35'sh0003FFFEA;
         5'd9:  r = 35'sh0001FFFFD;
         5'd10: r = 35'sh0000FFFFF;
         5'd11: r = 35'sh00007FFFF;
         5'd12: r = 35'sh00003FFFF;
         5'd13: r = 35'sh00001FFFF;
         5'd14: r = 35'sh00000FFFF;
         5'd15: r = 35'sh000007FFF;
         5'd16: r = 35'sh000003FFF;
         5'd17: r = 35'sh000001FFF;
         5'd18: r = 35'sh000000FFF;
         5'd19: r = 35'sh0000007FF;
         5'd20: r = 35'sh0000003FF;
         5'd21: r = 35'sh0000001FF;
         5'd22: r = 35'sh0000000FF;
         5'd23: r = 35'sh00000007F;
         5'd24: r = 35'sh00000003F;
         5'd25: r = 35'sh00000001F;
         5'd26: r = 35'sh00000000F;
         5'd27: r = 35'sh000000007;
         5'd28: r = 35'sh000000003;
         5'd29: r = 35'sh000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/tsa_cordic_cell.sv]
module tsa_cordic_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tsa_pkg::STEP_BITS-1:0]   step,
   input  logic                            valid_i,
   input  tsa_pkg::lane_type               lane_i,
   output logic                            valid_o,
   output tsa_pkg::lane_type               lane_o
);
   import tsa_pkg::*;

   logic              valid_ff;
   lane_type          lane_ff, lane_in;
   logic signed [LANE_BITS-1:0] sx, sy;
   logic              y_pos;

   // one vectoring micro-rotation, floor shifts
   always_comb begin
      sx    = lane_i.y >>> step;
      sy    = lane_i.x >>> step;
      y_pos = !lane_i.y[LANE_BITS-1] && (lane_i.y != '0);
      if (y_pos) begin
         lane_in.x = lane_i.x + sx;
         lane_in.y = lane_i.y - sy;
         lane_in.z = lane_i.z + atan_q30(step);
      end else begin
         lane_in.x = lane_i.x - sx;
         lane_in.y = lane_i.y + sy;
         lane_in.z = lane_i.z - atan_q30(step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_i;
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign valid_o = valid_ff;
   assign lane_o  = lane_ff;

endmodule

[rtl/core/tsa_window.sv]
module tsa_window (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic                                   restart,
   input  logic signed [tsa_pkg::ELEVATION_BITS-1:0] elevation,
   input  logic [tsa_pkg::ROW_CNT_BITS-1:0]       row_count,
   input  logic [tsa_pkg::COL_CNT_BITS-1:0]       column_count,
   output tsa_pkg::win_type                       win
);
   import tsa_pkg::*;

   logic signed [ELEVATION_BITS-1:0] upper_mem [MAX_COLUMNS];
   logic signed [ELEVATION_BITS-1:0] middle_mem [MAX_COLUMNS];
   logic signed [ELEVATION_BITS-1:0] upper_rd_ff, middle_rd_ff;
   logic signed [ELEVATION_BITS-1:0] win_ff [6];
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic row_end, col_end;
   logic signed [SUM_BITS-1:0] ea, eb, ec, ed, ef, eg, eh, ej;

   // line stores, read ahead at the current column
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_mem[col_ff]  <= middle_rd_ff;
         middle_mem[col_ff] <= elevation;
      end
      upper_rd_ff  <= upper_mem[col_ff];
      middle_rd_ff <= middle_mem[col_ff];
   end

   // two-column window shift
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= upper_rd_ff;
         win_ff[4] <= middle_rd_ff;
         win_ff[5] <= elevation;
      end
   end

   // raster position
   assign row_end = ({1'b0, row_ff} + 13'd1) >= row_count;
   assign col_end = ({1'b0, col_ff} + 11'd1) >= column_count;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + 12'd1;
      end else begin
         col_in = col_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Horn weighted differences
   always_comb begin
      ea = SUM_BITS'(win_ff[0]);
      ed = SUM_BITS'(win_ff[1]);
      eg = SUM_BITS'(win_ff[2]);
      eb = SUM_BITS'(win_ff[3]);
      eh = SUM_BITS'(win_ff[5]);
      ec = SUM_BITS'(upper_rd_ff);
      ef = SUM_BITS'(middle_rd_ff);
      ej = SUM_BITS'(elevation);
      win.sx = (ea + (ed <<< 1) + eg) - (ec + (ef <<< 1) + ej);
      win.sy = (ea + (eb <<< 1) + ec) - (eg + (eh <<< 1) + ej);
      win.row = row_ff;
      win.col = col_ff;
      win.interior = (row_ff >= 12'd2) && (col_ff >= 10'd2);
      win.border = (row_ff == '0) || (col_ff == '0) || row_end || col_end;
   end

endmodule

[rtl/core/terrain_slope_aspect_3x3.sv]
// Horn 3x3 slope and aspect of an elevation raster.
// Input channel req_*: one signed elevation sample per transaction, raster
// order. Result channel rsp_*: zero, one or two results per sample, the
// interior pixel completed by this sample first, then the sample's own
// border result; rsp_last_of_run marks the final one.
// Configuration via the APB-style port: row_count at 0x0, column_count at
// 0x4, gradient_scale at 0x8. Writing a frame size restarts the frame.
// Each sample runs through a product stage and two chains of 30 CORDIC
// cells (slope magnitude with aspect side by side, then the slope angle),
// one item in flight: a new sample is taken only once the results of the
// previous sample have all been taken.
// req_stall stays high while an item is in flight or results are pending,
// and for one cycle after a configuration write.
// Reset (synchronous) restores the register defaults and raster position
// 0,0; line store contents are undefined until written in the frame.
// While rsp_stall is high the pending result holds.
`include "terrain_slope_aspect_3x3_defines.svh"
module terrain_slope_aspect_3x3 (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [tsa_pkg::ELEVATION_BITS-1:0] req_elevation,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [tsa_pkg::ROW_BITS-1:0]              rsp_pixel_row,
   output logic [tsa_pkg::COL_BITS-1:0]              rsp_pixel_column,
   output logic [tsa_pkg::SLOPE_BITS-1:0]            rsp_slope_angle,
   output logic [tsa_pkg::ASPECT_BITS-1:0]           rsp_aspect_angle,
   output logic                                      rsp_last_of_run,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [3:0]                                paddr,
   input  logic [31:0]                               pwdata,
   output logic [31:0]                               prdata,
   output logic                                      pready
);
   import tsa_pkg::*;

   logic [ROW_CNT_BITS-1:0] row_count_ff;
   logic [COL_CNT_BITS-1:0] column_count_ff;
   logic [SCALE_BITS-1:0]   scale_ff;
   logic                    cfg_hold_ff;
   logic                    cfg_wr, restart, accept;
   reg_index_type           cfg_idx;
   logic [ROW_CNT_BITS-1:0] row_wr;
   logic [COL_CNT_BITS-1:0] col_wr;

   win_type                 win;
   state_type               state_ff, state_in;

   logic signed [SUM_BITS-1:0] sx_ff, sy_ff;
   logic [ROW_BITS-1:0]     row_ff;
   logic [COL_BITS-1:0]     col_ff;
   logic                    interior_ff, border_ff, sloped_ff;
   logic                    go1_ff, go2_ff;
   logic signed [PROD_BITS-1:0] gx_ff, gy_ff, gx_abs, gy_abs;
   logic signed [LANE_BITS-1:0] sx_w, sy_w, ax, ay;
   logic signed [Z_BITS-1:0]    asp_z_ff;
   logic [SLOPE_BITS-1:0]   slope_ff, slope_in;
   logic [ASPECT_BITS-1:0]  aspect_ff, aspect_in;
   logic signed [Z_BITS-1:0] zs, za, zr;

   logic     c1_v [CORDIC_STEPS+1];
   lane_type c1_s [CORDIC_STEPS+1];
   lane_type c1_a [CORDIC_STEPS+1];
   logic     c2_v [CORDIC_STEPS+1];
   lane_type c2_s [CORDIC_STEPS+1];

   // configuration registers
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = reg_index_type'(paddr[3:2]);
   assign restart = cfg_wr && ((cfg_idx == REG_ROW_COUNT) || (cfg_idx == REG_COLUMN_COUNT));
   assign pready  = 1'b1;

   always_comb begin
      row_wr = pwdata[ROW_CNT_BITS-1:0];
      if (row_wr < 13'd3) row_wr = 13'd3;
      if (row_wr > 13'(MAX_ROWS)) row_wr = 13'(MAX_ROWS);
      col_wr = pwdata[COL_CNT_BITS-1:0];
      if (col_wr < 11'd3) col_wr = 11'd3;
      if (col_wr > 11'(MAX_COLUMNS)) col_wr = 11'(MAX_COLUMNS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= 13'd1024;
         column_count_ff <= 11'd1024;
         scale_ff        <= 24'd65536;
         cfg_hold_ff     <= 1'b0;
      end else begin
         cfg_hold_ff <= cfg_wr;
         if (cfg_wr) begin
            unique case (cfg_idx)
               REG_ROW_COUNT:      row_count_ff    <= row_wr;
               REG_COLUMN_COUNT:   column_count_ff <= col_wr;
               REG_GRADIENT_SCALE: scale_ff        <= pwdata[SCALE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_ROW_COUNT:      prdata = 32'(row_count_ff);
         REG_COLUMN_COUNT:   prdata = 32'(column_count_ff);
         REG_GRADIENT_SCALE: prdata = 32'(scale_ff);
         default:            prdata = '0;
      endcase
   end

   // window and line stores
   assign req_stall = (state_ff != ST_IDLE) || cfg_hold_ff;
   assign accept    = req_valid && !req_stall;

   tsa_window u_window (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .restart      (restart),
      .elevation    (req_elevation),
      .row_count    (row_count_ff),
      .column_count (column_count_ff),
      .win          (win)
   );

   // capture the transaction's window sums and position, then form the scaled gradients
   always_ff @(posedge clock) begin
      if (accept) begin
         sx_ff       <= win.sx;
         sy_ff       <= win.sy;
         row_ff      <= win.row;
         col_ff      <= win.col;
         interior_ff <= win.interior;
         border_ff   <= win.border;
         sloped_ff   <= (scale_ff != '0) && ((win.sx != '0) || (win.sy != '0));
      end
      if (go1_ff) begin
         gx_ff <= PROD_BITS'(sx_ff) * PROD_BITS'($signed({1'b0, scale_ff}));
         gy_ff <= PROD_BITS'(sy_ff) * PROD_BITS'($signed({1'b0, scale_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go1_ff <= 1'b0;
         go2_ff <= 1'b0;
      end else begin
         go1_ff <= accept;
         go2_ff <= go1_ff;
      end
   end

   // lane set-up, quadrant pre-turn for aspect
   always_comb begin
      gx_abs = gx_ff[PROD_BITS-1] ? -gx_ff : gx_ff;
      gy_abs = gy_ff[PROD_BITS-1] ? -gy_ff : gy_ff;
      c1_v[0]   = go2_ff;
      c1_s[0].x = LANE_BITS'(gx_abs);
      c1_s[0].y = LANE_BITS'(gy_abs);
      c1_s[0].z = '0;
      sx_w = LANE_BITS'(sx_ff);
      sy_w = LANE_BITS'(sy_ff);
      ax = -(sy_w <<< ASPECT_PRESCALE);
      ay = sx_w <<< ASPECT_PRESCALE;
      if (ax[LANE_BITS-1]) begin
         if (!ay[LANE_BITS-1]) begin
            c1_a[0].x = ay;
            c1_a[0].y = -ax;
            c1_a[0].z = HALF_PI_Q30;
         end else begin
            c1_a[0].x = -ay;
            c1_a[0].y = ax;
            c1_a[0].z = -HALF_PI_Q30;
         end
      end else begin
         c1_a[0].x = ax;
         c1_a[0].y = ay;
         c1_a[0].z = '0;
      end
      c2_v[0]   = c1_v[CORDIC_STEPS];
      c2_s[0].x = GAIN_Q24;
      c2_s[0].y = c1_s[CORDIC_STEPS].x;
      c2_s[0].z = '0;
   end

   // two CORDIC cell chains
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_chain
      tsa_cordic_cell u_c1s (
         .clock (clock), .reset (reset), .step (STEP_BITS'(i)),
         .valid_i (c1_v[i]), .lane_i (c1_s[i]), .valid_o (c1_v[i+1]), .lane_o (c1_s[i+1])
      );
      tsa_cordic_cell u_c1a (
         .clock (clock), .reset (reset), .step (STEP_BITS'(i)),
         .valid_i (c1_v[i]), .lane_i (c1_a[i]), .valid_o (), .lane_o (c1_a[i+1])
      );
      tsa_cordic_cell u_c2s (
         .clock (clock), .reset (reset), .step (STEP_BITS'(i)),
         .valid_i (c2_v[i]), .lane_i (c2_s[i]), .valid_o (c2_v[i+1]), .lane_o (c2_s[i+1])
      );
   end

   // angle finishing: clamp, wrap, round
   always_comb begin
      zs = c2_s[CORDIC_STEPS].z;
      if (zs < 0) zs = '0;
      if (zs > HALF_PI_Q30) zs = HALF_PI_Q30;
      slope_in = SLOPE_BITS'((zs + ROUND_HALF) >>> ANGLE_SHIFT);
      za = asp_z_ff;
      if (za < 0) za = za + TWO_PI_Q30;
      if (za < 0) za = '0;
      zr = (za + ROUND_HALF) >>> ANGLE_SHIFT;
      if (!sloped_ff || (zr > ASPECT_MAX)) aspect_in = '0;
      else aspect_in = ASPECT_BITS'(zr);
   end

   always_ff @(posedge clock) begin
      if (c1_v[CORDIC_STEPS]) asp_z_ff <= c1_a[CORDIC_STEPS].z;
      if (c2_v[CORDIC_STEPS]) begin
         slope_ff  <= slope_in;
         aspect_ff <= aspect_in;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in         = state_ff;
      rsp_valid        = 1'b0;
      rsp_pixel_row    = row_ff;
      rsp_pixel_column = col_ff;
      rsp_slope_angle  = '0;
      rsp_aspect_angle = '0;
      rsp_last_of_run  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (c2_v[CORDIC_STEPS]) begin
               priority if (interior_ff) state_in = ST_EMIT_A;
               else if (border_ff) state_in = ST_EMIT_B;
               else state_in = ST_IDLE;
            end
         end
         ST_EMIT_A: begin
            rsp_valid        = 1'b1;
            rsp_pixel_row    = row_ff - 12'd1;
            rsp_pixel_column = col_ff - 10'd1;
            rsp_slope_angle  = slope_ff;
            rsp_aspect_angle = aspect_ff;
            rsp_last_of_run  = !border_ff;
            if (!rsp_stall) state_in = border_ff ? ST_EMIT_B : ST_IDLE;
         end
         ST_EMIT_B: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `TSA_ASSERT(a_accept_stalls, (req_valid && !req_stall) |=> req_stall, "accept not followed by stall")
   `TSA_ASSERT(a_done_in_busy, c2_v[CORDIC_STEPS] |-> (state_ff == ST_BUSY), "chain done outside busy")
   `TSA_ASSERT(a_one_in_flight, c1_v[CORDIC_STEPS] |-> !c2_v[CORDIC_STEPS], "two items in flight")
   `TSA_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_valid, "result right after reset")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
   import tsa_pkg::*;

   // expected result of one pixel
   typedef struct {
      logic [ROW_BITS-1:0]    row;
      logic [COL_BITS-1:0]    col;
      logic [SLOPE_BITS-1:0]  slope;
      logic [ASPECT_BITS-1:0] aspect;
      logic                   last;
   } pixel_angles_type;

   // Horn slope/aspect tracker: own raster position, line stores and window
   class slope_aspect_tracker;
      pixel_angles_type pending_angles[$];
      int unsigned   mismatches;
      int unsigned   rows_per_frame, cols_per_row, scale;
      longint        upper_line[MAX_COLUMNS];
      longint        middle_line[MAX_COLUMNS];
      longint        window[6];
      int unsigned   row_pos, col_pos;
      longint        atan_table[30];

      function new();
         atan_table = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
            64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
            64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
            64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
            64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003,
            64'h00000001};
         rows_per_frame = 1024;
         cols_per_row   = 1024;
         scale          = 65536;
         row_pos        = 0;
         col_pos        = 0;
         mismatches     = 0;
      endfunction

      // vectoring rotation towards y = 0; returns Q30 angle, x holds magnitude
      function longint rotate(inout longint x, input longint y);
         longint z, t, dx, dy;
         z = 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = HALF_PI_Q30;
            end else begin
               t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
         end
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += atan_table[i];
            end else begin
               x -= dx; y += dy; z -= atan_table[i];
            end
         end
         return z;
      endfunction

      function longint to_q16(longint z);
         return (z + 8192) >>> 14;
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] val);
         int unsigned v;
         case (idx)
            REG_ROW_COUNT: begin
               v = val[12:0];
               rows_per_frame = (v < 3) ? 3 : (v > MAX_ROWS) ? MAX_ROWS : v;
               row_pos = 0; col_pos = 0;
            end
            REG_COLUMN_COUNT: begin
               v = val[10:0];
               cols_per_row = (v < 3) ? 3 : (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
               row_pos = 0; col_pos = 0;
            end
            REG_GRADIENT_SCALE: scale = val[23:0];
            default: ;
         endcase
      endfunction

      function void push(int unsigned r, int unsigned c, longint sl, longint asp);
         pixel_angles_type e;
         e.row = r; e.col = c; e.slope = sl; e.aspect = asp; e.last = 0;
         pending_angles.push_back(e);
      endfunction

      // accepted sample: work out the results it causes
      function void note_sample(logic signed [ELEVATION_BITS-1:0] elev);
         longint v, up, mid, sx, sy, gx, gy, mx, x, z, sl, asp;
         int unsigned r, c;
         int n;
         v = elev; r = row_pos; c = col_pos; n = 0;
         up = upper_line[c]; mid = middle_line[c];
         upper_line[c] = mid; middle_line[c] = v;
         if (r >= 2 && c >= 2) begin
            sx = (window[0] + 2 * window[1] + window[2]) - (up + 2 * mid + v);
            sy = (window[0] + 2 * window[3] + up) - (window[2] + 2 * window[5] + v);
            gx = sx * longint'(scale);
            gy = sy * longint'(scale);
            mx = gx < 0 ? -gx : gx;
            void'(rotate(mx, gy < 0 ? -gy : gy));
            x = GAIN_Q24;
            z = rotate(x, mx);
            if (z < 0) z = 0;
            if (z > HALF_PI_Q30) z = HALF_PI_Q30;
            sl = to_q16(z);
            asp = 0;
            if (scale != 0 && (sx != 0 || sy != 0)) begin
               x = -sy * (longint'(1) << 38);
               z = rotate(x, sx * (longint'(1) << 38));
               if (z < 0) z += TWO_PI_Q30;
               if (z < 0) z = 0;
               asp = to_q16(z);
               if (asp > (longint'(TWO_PI_Q30) >>> 14)) asp = 0;
            end
            push(r - 1, c - 1, sl, asp);
            n++;
         end
         if (r == 0 || c == 0 || r + 1 >= rows_per_frame || c + 1 >= cols_per_row) begin
            push(r, c, 0, 0);
            n++;
         end
         window[0] = window[3]; window[1] = window[4]; window[2] = window[5];
         window[3] = up; window[4] = mid; window[5] = v;
         if (c + 1 >= cols_per_row) begin
            col_pos = 0;
            row_pos = (r + 1 >= rows_per_frame) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
         if (n > 0) pending_angles[$].last = 1;
      endfunction

      function void check_result(pixel_angles_type got);
         pixel_angles_type e;
         if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result row %0d col %0d", got.row, got.col);
            return;
         end
         e = pending_angles.pop_front();
         if (got.row !== e.row || got.col !== e.col || got.slope !== e.slope ||
             got.aspect !== e.aspect || got.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp r%0d c%0d s%0d a%0d l%0d, got r%0d c%0d s%0d a%0d l%0d",
                  e.row, e.col, e.slope, e.aspect, e.last,
                  got.row, got.col, got.slope, got.aspect, got.last);
         end
      endfunction
   endclass

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             req_valid = 0;
   logic                             req_stall;
   logic signed [ELEVATION_BITS-1:0] req_elevation = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 0;
   logic [ROW_BITS-1:0]              rsp_pixel_row;
   logic [COL_BITS-1:0]              rsp_pixel_column;
   logic [SLOPE_BITS-1:0]            rsp_slope_angle;
   logic [ASPECT_BITS-1:0]           rsp_aspect_angle;
   logic                             rsp_last_of_run;
   logic                             psel = 0, penable = 0, pwrite = 0;
   logic [3:0]                       paddr = '0;
   logic [31:0]                      pwdata = '0;
   logic [31:0]                      prdata;
   logic                             pready;
   logic                             quiet = 0;
   int unsigned                      sent = 0;
   int unsigned                      stall_left = 0;

   slope_aspect_tracker angles = new();

   terrain_slope_aspect_3x3 dut (.*);

   always #2 clock = ~clock;

   // watch both channels
   always @(posedge clock) begin
      pixel_angles_type got;
      if (!reset) begin
         if (req_valid && !req_stall) angles.note_sample(req_elevation);
         if (rsp_valid && !rsp_stall) begin
            got.row = rsp_pixel_row; got.col = rsp_pixel_column;
            got.slope = rsp_slope_angle; got.aspect = rsp_aspect_angle;
            got.last = rsp_last_of_run;
            angles.check_result(got);
         end
      end
   end

   // random result back-pressure in bursts, none while quiet
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else if (!rsp_stall && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_sample(input logic signed [ELEVATION_BITS-1:0] e);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1;
      req_elevation <= e;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   // drain all results plus the pipeline depth, end on a falling edge
   task automatic settle();
      req_valid <= 0;
      wait (angles.pending_angles.size() == 0);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] val);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock) penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0;
      angles.write_reg(idx, val);
      @(negedge clock);
   endtask

   // terrain generator: noise, ramps, flat or gentle noise
   function automatic logic [ELEVATION_BITS-1:0] terrain(int mode, int base, int kr,
                                                         int kc, int r, int c);
      case (mode)
         0: return ELEVATION_BITS'($urandom);
         1: return ELEVATION_BITS'(base + kr * r + kc * c);
         2: return ELEVATION_BITS'(base);
         default: return ELEVATION_BITS'(base + $signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   task automatic run_frame(int rows, int cols, int mode, int n);
      int base, kr, kc;
      base = $urandom; kr = $signed($urandom_range(0, 4000)) - 2000;
      kc = $signed($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < n; i++)
         send_sample(terrain(mode, base, kr, kc, (i / cols) % rows, i % cols));
   endtask

   initial begin
      int rows, cols, n;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: clamped small frame, extreme scale and samples
      write_reg(REG_ROW_COUNT, 0);
      write_reg(REG_COLUMN_COUNT, 1);
      write_reg(REG_GRADIENT_SCALE, 24'hFFFFFF);
      send_sample(20'sh80000); send_sample(20'sh7FFFF); send_sample(20'sh80000);
      send_sample(20'sh7FFFF); send_sample(20'sh80000); send_sample(20'sh7FFFF);
      send_sample(20'sh80000); send_sample(20'sh7FFFF); send_sample(20'sh80000);
      // flat ground, then negative aspect direction
      run_frame(3, 3, 2, 9);
      for (int i = 0; i < 9; i++) send_sample(ELEVATION_BITS'((i % 3) * 100));
      settle();
      write_reg(REG_GRADIENT_SCALE, 0);
      run_frame(3, 3, 0, 9);
      settle();

      // widest rows, tallest frame by clamping
      write_reg(REG_ROW_COUNT, 13'h1FFF);
      write_reg(REG_COLUMN_COUNT, 11'h7FF);
      write_reg(REG_GRADIENT_SCALE, 1);
      run_frame(4096, 1024, 0, 40);
      settle();

      // random frames, some cut short by a restart
      while (sent < 400) begin
         rows = $urandom_range(3, 6);
         cols = $urandom_range(3, 8);
         if (sent > 340) quiet = 1;
         write_reg(REG_ROW_COUNT, rows);
         write_reg(REG_COLUMN_COUNT, cols);
         case ($urandom_range(0, 3))
            0: write_reg(REG_GRADIENT_SCALE, $urandom);
            1: write_reg(REG_GRADIENT_SCALE, 24'hFFFFFF);
            2: write_reg(REG_GRADIENT_SCALE, $urandom_range(1, 255));
            default: ;
         endcase
         n = rows * cols * $urandom_range(1, 2);
         if ($urandom_range(0, 5) == 0) n = $urandom_range(1, rows * cols);
         run_frame(rows, cols, $urandom_range(0, 3), n);
         settle();
      end

      if (angles.mismatches == 0 && angles.pending_angles.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
